>>> rtl/range_max_segment_tree_unit_macros.svh
// assertion helpers shared by the range maximum block
`ifndef RANGE_MAX_SEGMENT_TREE_UNIT_MACROS_SVH
`define RANGE_MAX_SEGMENT_TREE_UNIT_MACROS_SVH

// same-cycle implication
`define RMST_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");

// next-cycle implication
`define RMST_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");

`endif

>>> rtl/rmst_pkg.sv
package rmst_pkg;

   localparam int ELEMENTS = 1024;
   localparam int NODES    = 2 * ELEMENTS;
   localparam int NODE_W   = $clog2(NODES);
   localparam int IDX_W    = NODE_W + 1;

   localparam int POS_W  = 10;
   localparam int DATA_W = 32;

   localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic {
      CMD_UPDATE = 1'b0,
      CMD_QUERY  = 1'b1
   } command_type;

   typedef enum logic [6:0] {
      ST_CLEAR   = 7'b0000001,
      ST_IDLE    = 7'b0000010,
      ST_UPD_WR  = 7'b0000100,
      ST_UPD_CMP = 7'b0001000,
      ST_Q_LEFT  = 7'b0010000,
      ST_Q_RIGHT = 7'b0100000,
      ST_DONE    = 7'b1000000
   } state_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] max_value;
      logic                     range_empty;
   } result_type;

   typedef struct packed {
      logic              wr_en;
      logic [NODE_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic [NODE_W-1:0] rd_addr;
   } mem_req_type;

endpackage

>>> rtl/rmst_ram.sv
module rmst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/rmst_max_unit.sv
module rmst_max_unit
   import rmst_pkg::*;
(
   input  logic signed [DATA_W-1:0] operand_a,
   input  logic signed [DATA_W-1:0] operand_b,
   output logic signed [DATA_W-1:0] larger
);

   assign larger = (operand_a > operand_b) ? operand_a : operand_b;

endmodule

>>> rtl/rmst_ctrl.sv
module rmst_ctrl
   import rmst_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  command_type              command,
   input  logic [POS_W-1:0]         position,
   input  logic signed [DATA_W-1:0] new_value,
   input  logic [POS_W-1:0]         query_low,
   input  logic [POS_W-1:0]         query_high,
   output logic                     res_valid,
   output result_type               res,
   input  logic                     res_taken,
   output mem_req_type              mem_req,
   input  logic [DATA_W-1:0]        mem_rd_data
);

   localparam logic [IDX_W-1:0] ELEM_IDX = IDX_W'(ELEMENTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ELEMENTS - 1);
   localparam logic [IDX_W-1:0] LAST_NODE = IDX_W'(NODES - 1);
   localparam logic [IDX_W-1:0] ROOT_IDX = IDX_W'(1);

   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         addr_ff, addr_in;
   logic [IDX_W-1:0]         right_ff, right_in;
   logic signed [DATA_W-1:0] cur_ff, cur_in;
   logic                     pend_ff, pend_in;
   logic                     empty_ff, empty_in;

   logic signed [DATA_W-1:0] larger;
   logic [IDX_W-1:0]         pos_idx;
   logic [IDX_W-1:0]         lo_idx;
   logic [IDX_W-1:0]         hi_idx;
   logic [IDX_W-1:0]         right_dec;

   rmst_max_unit u_max (
      .operand_a (cur_ff),
      .operand_b (mem_rd_data),
      .larger    (larger)
   );

   assign pos_idx   = IDX_W'(position);
   assign lo_idx    = IDX_W'(query_low);
   assign hi_idx    = (IDX_W'(query_high) > LAST_IDX) ? LAST_IDX : IDX_W'(query_high);
   assign right_dec = right_ff - ROOT_IDX;

   assign req_ready       = (state_ff == ST_IDLE);
   assign res_valid       = (state_ff == ST_DONE);
   assign res.max_value   = cur_ff;
   assign res.range_empty = empty_ff;

   always_comb begin
      state_in        = state_ff;
      addr_in         = addr_ff;
      right_in        = right_ff;
      cur_in          = cur_ff;
      pend_in         = pend_ff;
      empty_in        = empty_ff;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = addr_ff[NODE_W-1:0];
      mem_req.wr_data = cur_ff;
      mem_req.rd_addr = addr_ff[NODE_W-1:0];
      unique case (state_ff)
         ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_data = MOST_NEGATIVE;
            if (addr_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + ROOT_IDX;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (command == CMD_UPDATE) begin
                  if (pos_idx < ELEM_IDX) begin
                     addr_in  = ELEM_IDX + pos_idx;
                     cur_in   = new_value;
                     state_in = ST_UPD_WR;
                  end
               end else begin
                  cur_in  = MOST_NEGATIVE;
                  pend_in = 1'b0;
                  if (lo_idx > hi_idx || lo_idx >= ELEM_IDX) begin
                     empty_in = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     empty_in = 1'b0;
                     addr_in  = lo_idx + ELEM_IDX;
                     right_in = hi_idx + ELEM_IDX + ROOT_IDX;
                     state_in = ST_Q_LEFT;
                  end
               end
            end
         end
         ST_UPD_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.rd_addr = addr_ff[NODE_W-1:0] ^ NODE_W'(1);
            if (addr_ff == ROOT_IDX) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_UPD_CMP;
            end
         end
         ST_UPD_CMP: begin
            cur_in   = larger;
            addr_in  = addr_ff >> 1;
            state_in = ST_UPD_WR;
         end
         ST_Q_LEFT: begin
            if (pend_ff) begin
               cur_in = larger;
            end
            pend_in = 1'b0;
            if (addr_ff >= right_ff) begin
               state_in = ST_DONE;
            end else begin
               if (addr_ff[0]) begin
                  pend_in = 1'b1;
                  addr_in = addr_ff + ROOT_IDX;
               end
               state_in = ST_Q_RIGHT;
            end
         end
         ST_Q_RIGHT: begin
            if (pend_ff) begin
               cur_in = larger;
            end
            mem_req.rd_addr = right_dec[NODE_W-1:0];
            pend_in  = right_ff[0];
            addr_in  = addr_ff >> 1;
            right_in = right_ff >> 1;
            state_in = ST_Q_LEFT;
         end
         ST_DONE: begin
            if (res_taken) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      right_ff <= right_in;
      cur_ff   <= cur_in;
      empty_ff <= empty_in;
   end

endmodule

>>> rtl/range_max_segment_tree_unit.sv
// update: writes the leaf, then for each level reads the sibling, takes the larger and writes the parent
// query: walks both range bounds up the tree, merging boundary nodes; a reversed range goes straight to an empty result
// one request at a time; each node step waits on the registered read of the node memory
// result leaves through an output register, next request taken while it waits
// reset: synchronous, then a clearing pass writes the most negative value
// to every node, req_tready stays low meanwhile
module range_max_segment_tree_unit
   import rmst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // position, new_value, query_low, query_high, zero pad
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // max_value
   output logic        rsp_tuser    // range_empty
);

`include "range_max_segment_tree_unit_macros.svh"

   logic        res_valid;
   result_type  res;
   logic        res_taken;
   mem_req_type mem_req;
   logic [DATA_W-1:0] mem_rd_data;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_empty_ff, rsp_empty_in;

   rmst_ram #(
      .WIDTH (DATA_W),
      .DEPTH (NODES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rd_data)
   );

   rmst_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .command     (command_type'(req_tuser)),
      .position    (req_tdata[9:0]),
      .new_value   (req_tdata[41:10]),
      .query_low   (req_tdata[51:42]),
      .query_high  (req_tdata[61:52]),
      .res_valid   (res_valid),
      .res         (res),
      .res_taken   (res_taken),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data)
   );

   assign res_taken = res_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_empty_in = rsp_empty_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_taken) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res.max_value;
         rsp_empty_in = res.range_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_empty_ff;

   `RMST_ASSERT_NEXT(a_update_no_result, clock, reset, req_tvalid && req_tready && req_tuser == CMD_UPDATE, !res_valid)
   `RMST_ASSERT_NEXT(a_reversed_empty, clock, reset, req_tvalid && req_tready && req_tuser == CMD_QUERY && req_tdata[51:42] > req_tdata[61:52], res_valid && res.range_empty)
   `RMST_ASSERT_SAME(a_busy_while_result, clock, reset, res_valid, !req_tready)

endmodule
